// ===== rtl/fba_pkg.sv =====
// Shared types, codes and widths of the FAT block allocator.
`default_nettype none

package fba_pkg;

  // Fixed field widths
  localparam int SIZE_W    = 16;
  localparam int BB_W      = 8;
  localparam int FLD_IDX_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int NEED_W    = SIZE_W + 1;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = SIZE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BB_W-1:0] BLOCK_BYTES_RST = 8'd50;

  // Operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_PRESET = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_ZERO_SIZE  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC  = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [SIZE_W-1:0]    size_bytes;
    logic [FLD_IDX_W-1:0] chain_head;
    logic [FLD_IDX_W-1:0] block_index;
    logic                 used_flag;
  } fba_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FLD_IDX_W-1:0] start_block;
    logic [CNT_OUT_W-1:0] block_count;
  } fba_out_t;

  // Divider result toward the sequencer
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quotient;
    logic              rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/fat_block_allocator_unit.sv =====
// Top level of the FAT block allocator: sequencer, bitmap and link-table control.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | fba_in_t (operation, sizes, ids)
//  out_    | output    | out_valid/out_stall| fba_out_t (status, start, count)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_data = block_bytes
//
// Preset, unused operations, zero size and rejected frees go straight to done.
// Allocate runs the divider, then scans the bitmap entry by entry (at most
// NUM_BLOCKS entries), then marks the chain end before done.
// An allocate that lacks space goes to done as soon as the divider finishes.
// Free reads each chain link (registered link-table read), then updates it.
// Reset clears bitmap and link-valid flags at once; no clearing pass.
// A finished item waits in the output register; while the port stalls, the
// next item is accepted and runs until it, in turn, waits for the register.
`default_nettype none

module fat_block_allocator_unit #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire fba_pkg::fba_in_t      in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output fba_pkg::fba_out_t          out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [fba_pkg::BB_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DIV     = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_LINKEND = 7'b0001000,
    S_WRD     = 7'b0010000,
    S_WUPD    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [NUM_BLOCKS-1:0] link_vld_r, link_vld_nxt;
  logic [CNT_W-1:0]      free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]      taken_r, taken_nxt;
  logic [NEED_W-1:0]     need_r, need_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      prev_r, prev_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  fba_out_t              res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fba_out_t              out_data_r, out_data_nxt;
  logic [BB_W-1:0]       block_bytes_r;

  logic                  in_acc;
  logic [BB_W-1:0]       bsz;
  logic                  div_start;
  div_res_t              div_res;
  logic [NEED_W-1:0]     need_calc;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;
  logic [LINK_W-1:0]     mem_rdata;
  logic [CNT_W-1:0]      walk_cnt;
  logic [IDX_W-1:0]      pre_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      next_idx;
  logic                  walk_stop;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A block size of zero counts as one
  assign bsz = (block_bytes_r == '0) ? BB_W'(1) : block_bytes_r;

  assign need_calc = NEED_W'(div_res.quotient) + NEED_W'(div_res.rem_nz);
  assign pre_idx   = IDX_W'(in_data.block_index);
  assign free_idx  = IDX_W'(in_data.chain_head);
  assign next_idx  = IDX_W'(mem_rdata);
  assign walk_cnt  = taken_r + CNT_W'(1);
  assign walk_stop = (mem_rdata >= LINK_END) || (next_idx == cur_r) ||
                     !link_vld_r[next_idx] || (walk_cnt == CNT_W'(NUM_BLOCKS));

  fba_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.size_bytes),
    .divisor  (bsz),
    .res      (div_res)
  );

  fba_link_mem #(
    .DEPTH  (NUM_BLOCKS),
    .ADDR_W (IDX_W),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cur_r),
    .rdata (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    link_vld_nxt  = link_vld_r;
    free_cnt_nxt  = free_cnt_r;
    taken_nxt     = taken_r;
    need_nxt      = need_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = prev_r;
    mem_wdata     = LINK_END;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt   = '{status: ST_OK, start_block: '0, block_count: '0};
          state_nxt = S_DONE;
          case (in_data.operation)
            OP_ALLOC: begin
              if (in_data.size_bytes == '0) begin
                res_nxt.status = ST_ZERO_SIZE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_FREE: begin
              if ((32'(in_data.chain_head) >= NUM_BLOCKS) ||
                  !link_vld_r[free_idx]) begin
                res_nxt.status = ST_NOT_ALLOC;
              end else begin
                cur_nxt   = free_idx;
                taken_nxt = '0;
                state_nxt = S_WRD;
              end
            end
            OP_PRESET: begin
              // Write one used flag and keep the free count in step
              if (32'(in_data.block_index) < NUM_BLOCKS &&
                  used_r[pre_idx] != in_data.used_flag) begin
                used_nxt[pre_idx] = in_data.used_flag;
                free_cnt_nxt = in_data.used_flag ? free_cnt_r - CNT_W'(1)
                                                 : free_cnt_r + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          need_nxt = need_calc;
          if (need_calc > NEED_W'(free_cnt_r)) begin
            res_nxt   = '{status: ST_NO_SPACE, start_block: '0, block_count: '0};
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = '0;
            taken_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Take the next free block and link the previous one to it
        if (!used_r[idx_r]) begin
          used_nxt[idx_r] = 1'b1;
          free_cnt_nxt    = free_cnt_r - CNT_W'(1);
          if (taken_r == '0) begin
            first_nxt = idx_r;
          end else begin
            mem_we               = 1'b1;
            mem_wdata            = LINK_W'(idx_r);
            link_vld_nxt[prev_r] = 1'b1;
          end
          prev_nxt  = idx_r;
          taken_nxt = taken_r + CNT_W'(1);
          if (NEED_W'(taken_r) + NEED_W'(1) == need_r) begin
            state_nxt = S_LINKEND;
          end
        end
        idx_nxt = idx_r + IDX_W'(1);
      end

      S_LINKEND: begin
        // Mark the last block as chain end
        mem_we               = 1'b1;
        mem_wdata            = LINK_END;
        link_vld_nxt[prev_r] = 1'b1;
        res_nxt   = '{status: ST_OK, start_block: FLD_IDX_W'(first_r),
                      block_count: CNT_OUT_W'(taken_r)};
        state_nxt = S_DONE;
      end

      S_WRD: begin
        state_nxt = S_WUPD;
      end

      S_WUPD: begin
        // Release the current link and follow it unless the chain ends
        link_vld_nxt[cur_r] = 1'b0;
        if (used_r[cur_r]) begin
          used_nxt[cur_r] = 1'b0;
          free_cnt_nxt    = free_cnt_r + CNT_W'(1);
        end
        taken_nxt = walk_cnt;
        if (walk_stop) begin
          res_nxt   = '{status: ST_OK, start_block: '0,
                        block_count: CNT_OUT_W'(walk_cnt)};
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = next_idx;
          state_nxt = S_WRD;
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      used_r        <= '0;
      link_vld_r    <= '0;
      free_cnt_r    <= CNT_W'(NUM_BLOCKS);
      out_valid_r   <= 1'b0;
      block_bytes_r <= BLOCK_BYTES_RST;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      link_vld_r  <= link_vld_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        block_bytes_r <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    taken_r    <= taken_nxt;
    need_r     <= need_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_free_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(NUM_BLOCKS))
    else $error("free block count above block total");

  a_scan_space: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |->
      (NEED_W'(free_cnt_r) + NEED_W'(taken_r) >= need_r))
    else $error("allocation scan lacks free blocks");

  a_walk_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WUPD) |-> link_vld_r[cur_r])
    else $error("chain walk on an unlinked entry");

  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN || state_r == S_LINKEND))
    else $error("link table written outside allocation");

endmodule

`default_nettype wire

// ===== rtl/fba_divider.sv =====
// Restoring divider: byte size over block size, one bit per cycle.
`default_nettype none

module fba_divider (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [fba_pkg::SIZE_W-1:0] dividend,
  input  wire logic [fba_pkg::BB_W-1:0]   divisor,
  output fba_pkg::div_res_t             res
);
  import fba_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    quo_r, quo_nxt;
  logic [BB_W-1:0]      rem_r, rem_nxt;
  logic [BB_W-1:0]      dvs_r, dvs_nxt;
  logic [BB_W:0]        trial;
  logic [BB_W:0]        diff;
  logic                 ge;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[SIZE_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[BB_W-1:0] : trial[BB_W-1:0];
      quo_nxt = {quo_r[SIZE_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end
  end

  // Control state resets, datapath holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;
  assign res.rem_nz   = |rem_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r)
    else $error("divider did not start");

endmodule

`default_nettype wire

// ===== rtl/fba_link_mem.sv =====
// Next-link table storage: one write port, one registered read port.
`default_nettype none

module fba_link_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write one link entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
